FILE: rtl/rgbhsv_pkg.sv
// shared widths and constants for the rgb to hsv converter
package rgbhsv_pkg;

   localparam int CHAN_W     = 8;
   localparam int PIXEL_W    = 3 * CHAN_W;
   localparam int SEXT_W     = 3;
   localparam int HUE_FRAC_W = 12;
   localparam int HUE_W      = SEXT_W + HUE_FRAC_W;
   localparam int SAT_W      = 17;
   localparam int QUOT_W     = 17;
   localparam int DIV_STAGES = QUOT_W;
   localparam int FRAC_SHIFT = QUOT_W - 1 - HUE_FRAC_W;
   localparam int FRAC_W     = QUOT_W - FRAC_SHIFT;
   localparam int FRAC_ONE   = 1 << HUE_FRAC_W;

   localparam logic [SEXT_W-1:0] SEXT_RED_YELLOW    = 3'd0;
   localparam logic [SEXT_W-1:0] SEXT_YELLOW_GREEN  = 3'd1;
   localparam logic [SEXT_W-1:0] SEXT_GREEN_CYAN    = 3'd2;
   localparam logic [SEXT_W-1:0] SEXT_CYAN_BLUE     = 3'd3;
   localparam logic [SEXT_W-1:0] SEXT_BLUE_MAGENTA  = 3'd4;
   localparam logic [SEXT_W-1:0] SEXT_MAGENTA_RED   = 3'd5;

endpackage

FILE: rtl/rgbhsv_div.sv
// pipelined restoring divider, floor(dividend * 2^16 / divisor), one quotient bit per stage
module rgbhsv_div (
   input  logic                             clock,
   input  logic [rgbhsv_pkg::CHAN_W-1:0]    dividend,
   input  logic [rgbhsv_pkg::CHAN_W-1:0]    divisor,
   output logic [rgbhsv_pkg::QUOT_W-1:0]    quotient
);
   import rgbhsv_pkg::*;

   // dividend never exceeds divisor, so the remainder always fits in CHAN_W bits
   logic [CHAN_W-1:0] rem_ff [DIV_STAGES];
   logic [CHAN_W-1:0] rem_in [DIV_STAGES];
   logic [CHAN_W-1:0] den_ff [DIV_STAGES];
   logic [CHAN_W-1:0] den_in [DIV_STAGES];
   logic [QUOT_W-1:0] quo_ff [DIV_STAGES];
   logic [QUOT_W-1:0] quo_in [DIV_STAGES];
   logic [QUOT_W-1:0] quo_prev [DIV_STAGES];
   logic [CHAN_W:0]   trial [DIV_STAGES];
   logic [CHAN_W:0]   diff [DIV_STAGES];
   logic              take [DIV_STAGES];

   genvar k;
   generate
      for (k = 0; k < DIV_STAGES; k++) begin : g_stage
         if (k == 0) begin : g_first
            assign trial[k]    = {1'b0, dividend};
            assign den_in[k]   = divisor;
            assign quo_prev[k] = '0;
         end else begin : g_next
            assign trial[k]    = {rem_ff[k-1], 1'b0};
            assign den_in[k]   = den_ff[k-1];
            assign quo_prev[k] = quo_ff[k-1];
         end

         // zero divisor yields a zero quotient
         assign take[k]   = (den_in[k] != '0) && (trial[k] >= {1'b0, den_in[k]});
         assign diff[k]   = trial[k] - {1'b0, den_in[k]};
         assign rem_in[k] = take[k] ? diff[k][CHAN_W-1:0] : trial[k][CHAN_W-1:0];
         assign quo_in[k] = {quo_prev[k][QUOT_W-2:0], take[k]};

         always_ff @(posedge clock) begin
            rem_ff[k] <= rem_in[k];
            den_ff[k] <= den_in[k];
            quo_ff[k] <= quo_in[k];
         end
      end
   endgenerate

   assign quotient = quo_ff[DIV_STAGES-1];

endmodule

FILE: rtl/rgb_to_hsv_converter_top.sv
// rgb to hsv converter: top level with channel sort, two dividers and hue assembly
//
// Takes one packed RGB pixel per clock with no gaps needed: busy is never raised, so a
// pixel is taken at every edge where start is high. Each result appears on the rsp_ ports
// for one cycle, flagged by rsp_strobe, in input order. The pixel passes through input and
// sort registers, the two 17-stage restoring dividers (saturation and hue fraction, one
// quotient bit per stage) and output registers. Hue is in sextants with 12 fraction bits,
// saturation is Q1.16 with 65536 meaning 1.0, and brightness is the largest channel. The
// receiver cannot stall; results must be captured on the strobe.
module rgb_to_hsv_converter_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [rgbhsv_pkg::PIXEL_W-1:0]    req_pixel_rgb,
   output logic                              rsp_strobe,
   output logic [rgbhsv_pkg::HUE_W-1:0]      rsp_hue,
   output logic [rgbhsv_pkg::SAT_W-1:0]      rsp_saturation,
   output logic [rgbhsv_pkg::CHAN_W-1:0]     rsp_brightness
);
   import rgbhsv_pkg::*;

   // input register
   logic               pix_vld_ff, pix_vld_in;
   logic [PIXEL_W-1:0] pix_ff;

   // sort stage
   logic [CHAN_W-1:0]  red, green, blue;
   logic [CHAN_W-1:0]  hi_in, mid_in, lo_in;
   logic [SEXT_W-1:0]  sext_in;
   logic               srt_vld_ff;
   logic [CHAN_W-1:0]  hi_ff, span_ff, delta_ff;
   logic [SEXT_W-1:0]  sext_ff;

   // sideband alongside the dividers
   logic               sb_vld_ff  [DIV_STAGES];
   logic [SEXT_W-1:0]  sb_sext_ff [DIV_STAGES];
   logic [CHAN_W-1:0]  sb_hi_ff   [DIV_STAGES];

   // divider results and output stage
   logic [QUOT_W-1:0]  sat_quo, frac_quo;
   logic [FRAC_W-1:0]  frac;
   logic [SEXT_W-1:0]  sext_end;
   logic [HUE_W-1:0]   hue_base, hue_in;
   logic               rsp_strobe_ff;
   logic [HUE_W-1:0]   rsp_hue_ff;
   logic [SAT_W-1:0]   rsp_sat_ff;
   logic [CHAN_W-1:0]  rsp_bright_ff;

   assign busy       = 1'b0;
   assign pix_vld_in = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_vld_ff <= 1'b0;
      end else begin
         pix_vld_ff <= pix_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff <= req_pixel_rgb;
   end

   assign red   = pix_ff[3*CHAN_W-1:2*CHAN_W];
   assign green = pix_ff[2*CHAN_W-1:CHAN_W];
   assign blue  = pix_ff[CHAN_W-1:0];

   // comparison tree; ties fall to the first matching branch
   always_comb begin
      hi_in   = red;
      mid_in  = green;
      lo_in   = blue;
      sext_in = SEXT_RED_YELLOW;
      priority if (green > red) begin
         priority if (red > blue) begin
            hi_in = green; mid_in = red;   lo_in = blue; sext_in = SEXT_YELLOW_GREEN;
         end else if (blue > green) begin
            hi_in = blue;  mid_in = green; lo_in = red;  sext_in = SEXT_CYAN_BLUE;
         end else begin
            hi_in = green; mid_in = blue;  lo_in = red;  sext_in = SEXT_GREEN_CYAN;
         end
      end else if (green < blue) begin
         priority if (red > blue) begin
            hi_in = red;   mid_in = blue;  lo_in = green; sext_in = SEXT_MAGENTA_RED;
         end else begin
            hi_in = blue;  mid_in = red;   lo_in = green; sext_in = SEXT_BLUE_MAGENTA;
         end
      end else begin
         hi_in   = red;
         mid_in  = green;
         lo_in   = blue;
         sext_in = SEXT_RED_YELLOW;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         srt_vld_ff <= 1'b0;
      end else begin
         srt_vld_ff <= pix_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      hi_ff    <= hi_in;
      span_ff  <= hi_in - lo_in;
      delta_ff <= mid_in - lo_in;
      sext_ff  <= sext_in;
   end

   // saturation = floor(2^16 * span / max)
   rgbhsv_div u_sat_div (
      .clock    (clock),
      .dividend (span_ff),
      .divisor  (hi_ff),
      .quotient (sat_quo)
   );

   // hue fraction computed at 16 bits and cut down to 12, floor of floor is exact
   rgbhsv_div u_frac_div (
      .clock    (clock),
      .dividend (delta_ff),
      .divisor  (span_ff),
      .quotient (frac_quo)
   );

   genvar k;
   generate
      for (k = 0; k < DIV_STAGES; k++) begin : g_sb
         if (k == 0) begin : g_first
            always_ff @(posedge clock) begin
               if (reset) begin
                  sb_vld_ff[k] <= 1'b0;
               end else begin
                  sb_vld_ff[k] <= srt_vld_ff;
               end
            end
            always_ff @(posedge clock) begin
               sb_sext_ff[k] <= sext_ff;
               sb_hi_ff[k]   <= hi_ff;
            end
         end else begin : g_next
            always_ff @(posedge clock) begin
               if (reset) begin
                  sb_vld_ff[k] <= 1'b0;
               end else begin
                  sb_vld_ff[k] <= sb_vld_ff[k-1];
               end
            end
            always_ff @(posedge clock) begin
               sb_sext_ff[k] <= sb_sext_ff[k-1];
               sb_hi_ff[k]   <= sb_hi_ff[k-1];
            end
         end
      end
   endgenerate

   assign frac     = frac_quo[QUOT_W-1:FRAC_SHIFT];
   assign sext_end = sb_sext_ff[DIV_STAGES-1];
   assign hue_base = {sext_end, {HUE_FRAC_W{1'b0}}};

   // odd sextants run backward from the next sextant boundary
   always_comb begin
      if (sext_end[0]) begin
         hue_in = hue_base + HUE_W'(FRAC_ONE) - HUE_W'(frac);
      end else begin
         hue_in = hue_base + HUE_W'(frac);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= sb_vld_ff[DIV_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      rsp_hue_ff    <= hue_in;
      rsp_sat_ff    <= SAT_W'(sat_quo);
      rsp_bright_ff <= sb_hi_ff[DIV_STAGES-1];
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_hue        = rsp_hue_ff;
   assign rsp_saturation = rsp_sat_ff;
   assign rsp_brightness = rsp_bright_ff;

endmodule

FILE: bench/rgb_to_hsv_converter_top_tb.sv
// self-checking bench for the rgb to hsv converter: directed and random pixels, scoreboard
`timescale 1ns / 1ps

class hsv_scoreboard;
   typedef struct {
      logic [rgbhsv_pkg::PIXEL_W-1:0] pixel;
      logic [rgbhsv_pkg::HUE_W-1:0]   hue;
      logic [rgbhsv_pkg::SAT_W-1:0]   saturation;
      logic [rgbhsv_pkg::CHAN_W-1:0]  brightness;
   } hsv_expect_type;

   hsv_expect_type expected_hsv[$];
   int unsigned mismatches;

   function new();
      mismatches = 0;
   endfunction

   function hsv_expect_type convert_pixel(logic [rgbhsv_pkg::PIXEL_W-1:0] pixel);
      logic [rgbhsv_pkg::CHAN_W-1:0] r, g, b, hi, mid, lo, span;
      logic [rgbhsv_pkg::SEXT_W-1:0] sext;
      logic [24:0] sat_q;
      logic [19:0] frac_q;
      logic [15:0] hue_full;
      hsv_expect_type e;
      r = pixel[23:16];
      g = pixel[15:8];
      b = pixel[7:0];
      hi = r; mid = g; lo = b; sext = rgbhsv_pkg::SEXT_RED_YELLOW;
      if (g > r) begin
         if (r > b) begin
            hi = g; mid = r; lo = b; sext = rgbhsv_pkg::SEXT_YELLOW_GREEN;
         end else if (b > g) begin
            hi = b; mid = g; lo = r; sext = rgbhsv_pkg::SEXT_CYAN_BLUE;
         end else begin
            hi = g; mid = b; lo = r; sext = rgbhsv_pkg::SEXT_GREEN_CYAN;
         end
      end else if (g < b) begin
         if (r > b) begin
            hi = r; mid = b; lo = g; sext = rgbhsv_pkg::SEXT_MAGENTA_RED;
         end else begin
            hi = b; mid = r; lo = g; sext = rgbhsv_pkg::SEXT_BLUE_MAGENTA;
         end
      end
      span = hi - lo;
      sat_q = (hi == 0) ? 25'd0 : {1'b0, span, 16'd0} / {17'd0, hi};
      // fraction reaches a full sextant when mid equals max
      frac_q = (span == 0) ? 20'd0 : {mid - lo, 12'd0} / {12'd0, span};
      if (sext[0])
         hue_full = ({13'd0, sext} + 16'd1) * 16'd4096 - frac_q[15:0];
      else
         hue_full = {13'd0, sext} * 16'd4096 + frac_q[15:0];
      e.pixel      = pixel;
      e.hue        = hue_full[rgbhsv_pkg::HUE_W-1:0];
      e.saturation = sat_q[rgbhsv_pkg::SAT_W-1:0];
      e.brightness = hi;
      return e;
   endfunction

   function void note_pixel(logic [rgbhsv_pkg::PIXEL_W-1:0] pixel);
      expected_hsv.push_back(convert_pixel(pixel));
   endfunction

   function void check_result(logic [rgbhsv_pkg::HUE_W-1:0] hue,
                              logic [rgbhsv_pkg::SAT_W-1:0] saturation,
                              logic [rgbhsv_pkg::CHAN_W-1:0] brightness);
      hsv_expect_type e;
      if (expected_hsv.size() == 0) begin
         mismatches++;
         $display("%0t: result with nothing pending: hue %0d sat %0d bright %0d",
                  $realtime, hue, saturation, brightness);
         return;
      end
      e = expected_hsv.pop_front();
      if (hue !== e.hue) begin
         mismatches++;
         $display("%0t: pixel %06h hue expected %0d actual %0d",
                  $realtime, e.pixel, e.hue, hue);
      end
      if (saturation !== e.saturation) begin
         mismatches++;
         $display("%0t: pixel %06h saturation expected %0d actual %0d",
                  $realtime, e.pixel, e.saturation, saturation);
      end
      if (brightness !== e.brightness) begin
         mismatches++;
         $display("%0t: pixel %06h brightness expected %0d actual %0d",
                  $realtime, e.pixel, e.brightness, brightness);
      end
   endfunction

   function int unsigned pending();
      return expected_hsv.size();
   endfunction
endclass

module rgb_to_hsv_converter_top_tb;
   localparam int RANDOM_PIXELS = 850;
   localparam int CALM_TAIL     = 120;
   localparam int DRAIN_CYCLES  = 40;
   localparam int CYCLE_LIMIT   = 300000;

   logic                             clock;
   logic                             reset;
   logic                             start;
   logic                             busy;
   logic [rgbhsv_pkg::PIXEL_W-1:0]   req_pixel_rgb;
   logic                             rsp_strobe;
   logic [rgbhsv_pkg::HUE_W-1:0]     rsp_hue;
   logic [rgbhsv_pkg::SAT_W-1:0]     rsp_saturation;
   logic [rgbhsv_pkg::CHAN_W-1:0]    rsp_brightness;

   hsv_scoreboard hsv_sb;
   int unsigned   cycle_count;

   rgb_to_hsv_converter_top DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_pixel_rgb  (req_pixel_rgb),
      .rsp_strobe     (rsp_strobe),
      .rsp_hue        (rsp_hue),
      .rsp_saturation (rsp_saturation),
      .rsp_brightness (rsp_brightness)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // check before noting: a result never belongs to the pixel taken at the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe)
            hsv_sb.check_result(rsp_hue, rsp_saturation, rsp_brightness);
         if (start && !busy)
            hsv_sb.note_pixel(req_pixel_rgb);
      end
   end

   task automatic send_pixel(logic [rgbhsv_pkg::PIXEL_W-1:0] pixel);
      @(negedge clock);
      start         <= 1'b1;
      req_pixel_rgb <= pixel;
      do @(posedge clock); while (busy);
   endtask

   task automatic hold_off(int unsigned n);
      repeat (n) begin
         @(negedge clock);
         start         <= 1'b0;
         req_pixel_rgb <= rgbhsv_pkg::PIXEL_W'($urandom);
      end
   endtask

   function automatic logic [rgbhsv_pkg::PIXEL_W-1:0] pick_pixel();
      logic [7:0] c0, c1, c2, base;
      c0 = 8'($urandom); c1 = 8'($urandom); c2 = 8'($urandom);
      case ($urandom_range(0, 9))
         4: begin
            c1 = c0; c2 = c0;                        // gray
         end
         5: begin
            if ($urandom_range(0, 1)) c1 = c0; else c2 = c1;   // two channels tied
         end
         6: begin
            base = 8'($urandom_range(0, 250));       // channels close together
            c0 = base + 8'($urandom_range(0, 5));
            c1 = base + 8'($urandom_range(0, 5));
            c2 = base + 8'($urandom_range(0, 5));
         end
         7: begin
            c0 = $urandom_range(0, 1) ? 8'hff : 8'h00;
            c2 = $urandom_range(0, 1) ? 8'hff : 8'h00;
         end
         8: begin
            c0 = 8'($urandom_range(0, 3));           // very dark
            c1 = 8'($urandom_range(0, 3));
            c2 = 8'($urandom_range(0, 3));
         end
         default: ;
      endcase
      case ($urandom_range(0, 2))
         0: return {c0, c1, c2};
         1: return {c1, c2, c0};
         default: return {c2, c0, c1};
      endcase
   endfunction

   logic [rgbhsv_pkg::PIXEL_W-1:0] directed_pixels[$] = '{
      24'h000000, 24'hffffff, 24'h808080, 24'h010101,
      24'hff0000, 24'h00ff00, 24'h0000ff,
      24'hffff00, 24'h00ffff, 24'hff00ff,
      24'hff8000, 24'h80ff00, 24'h00ff80, 24'h0080ff, 24'h8000ff, 24'hff0080,
      24'h010000, 24'h000100, 24'h000001,
      24'hfefeff, 24'hfffe00, 24'h7f807f, 24'h0a0b0c, 24'hc8641e, 24'h555555
   };

   initial begin
      bit gappy;
      hsv_sb        = new();
      cycle_count   = 0;
      reset         = 1'b1;
      start         = 1'b0;
      req_pixel_rgb = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_pixels[i]) begin
         send_pixel(directed_pixels[i]);
         if (i % 4 == 3)
            hold_off($urandom_range(1, 19));
      end

      gappy = 1'b1;
      for (int i = 0; i < RANDOM_PIXELS; i++) begin
         send_pixel(pick_pixel());
         // alternate between gappy stretches and back-to-back stretches
         if ($urandom_range(0, 59) == 0)
            gappy = ~gappy;
         if (i < RANDOM_PIXELS - CALM_TAIL && gappy && $urandom_range(0, 2) == 0)
            hold_off($urandom_range(1, 19));
      end
      @(negedge clock);
      start <= 1'b0;

      while (hsv_sb.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (hsv_sb.mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule

FILE: filelist.f
rtl/rgbhsv_pkg.sv
rtl/rgbhsv_div.sv
rtl/rgb_to_hsv_converter_top.sv
bench/rgb_to_hsv_converter_top_tb.sv
